>>> hw/rtl/sbsu_pkg.sv
// Package for the single-button setpoint user interface.
// Holds widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package sbsu_pkg;

    // Timer and temperature widths
    localparam int TIMER_BITS = 16;
    localparam int TEMP_W     = 7;
    localparam int RANGE_W    = 4;

    // Defaults for the top-level parameters
    localparam int BAR_LEDS_DEF         = 8;
    localparam int DEFAULT_SETPOINT_DEF = 36;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP_ADULT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP_CHILD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ON_OFF_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_DONE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_PERIOD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_RANGE     = 3'd7;

    // Register reset values
    localparam logic [TEMP_W-1:0]     RST_MIN_TEMP       = 7'd30;
    localparam logic [TEMP_W-1:0]     RST_MAX_TEMP_ADULT = 7'd37;
    localparam logic [TEMP_W-1:0]     RST_MAX_TEMP_CHILD = 7'd35;
    localparam logic [TIMER_BITS-1:0] RST_LONG_PRESS     = 16'd1000;
    localparam logic [TIMER_BITS-1:0] RST_ON_OFF_LIMIT   = 16'd3000;
    localparam logic [TIMER_BITS-1:0] RST_ACTIVITY_DONE  = 16'd3000;
    localparam logic [TIMER_BITS-1:0] RST_BAR_PERIOD     = 16'd375;
    localparam logic [RANGE_W-1:0]    RST_TEMP_RANGE     = 4'd8;

    // Poll sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BAR,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/single_button_setpoint_ui.sv
// Top level of the single-button setpoint user interface.
// Depends on sbsu_pkg and sbsu_div.
`default_nettype none

// One button poll enters on the slave stream and produces exactly one result on
// the master stream. A poll that draws the power-toggle LED bar has its result
// shown only after the divide: the bar length comes from the hold time past the
// long-press time divided by the bar step period, worked out one quotient bit per
// cycle in the divider. Every other poll is shown in the cycle after its transfer.
// The result register holds until the master side takes it, and the next poll is
// taken only after that.

module single_button_setpoint_ui #(
    parameter int BAR_LEDS         = sbsu_pkg::BAR_LEDS_DEF,
    parameter int DEFAULT_SETPOINT = sbsu_pkg::DEFAULT_SETPOINT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [sbsu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sbsu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Poll stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pressed[0], press_time[16:1], release_time[32:17], zero pad
    input  wire logic [39:0]                       s_axis_tdata,
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // beep_start, bar_update, bar_pattern[BAR_LEDS], setpoint[7], target_temp[7],
    // power_on, adult_on, store_request, busy_res, editing_setpoint,
    // arming_power, editing_mode, zero pad
    output logic [((BAR_LEDS + 23 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int TB     = sbsu_pkg::TIMER_BITS;
    localparam int TW     = sbsu_pkg::TEMP_W;
    localparam int RW     = sbsu_pkg::RANGE_W;
    localparam int OUT_W  = BAR_LEDS + 23;
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;
    localparam int LEN_W  = TB + 2;

    // Configuration registers
    logic [TW-1:0] r_min_temp, r_max_adult, r_max_child;
    logic [TB-1:0] r_long_press, r_on_off_limit, r_activity_done, r_bar_period;
    logic [RW-1:0] r_temp_range;

    // User interface state
    logic          r_was_pressed, n_was_pressed;
    logic [TB-1:0] r_longest_hold, n_longest_hold;
    logic          r_edit_temp, n_edit_temp;
    logic          r_arm_power, n_arm_power;
    logic          r_edit_mode, n_edit_mode;
    logic          r_skip_first, n_skip_first;
    logic          r_busy, n_busy;
    logic [TW-1:0] r_setpoint, n_setpoint;
    logic [TW-1:0] r_target, n_target;
    logic          r_power, n_power;
    logic          r_adult, n_adult;

    // Result payload
    logic                r_beep, n_beep;
    logic                r_bar_upd, n_bar_upd;
    logic                r_store, n_store;
    logic [BAR_LEDS-1:0] r_pattern;
    logic                r_neg;
    logic                r_count_down;

    // Sequencer
    sbsu_pkg::t_state r_state, n_state;
    logic             w_accept;
    logic             w_need_bar;
    logic             w_div_start;
    logic             w_div_done;
    logic [TB-1:0]    w_quot;

    // Poll fields
    logic          w_pressed;
    logic [TB-1:0] w_press_time;
    logic [TB-1:0] w_release_time;

    // Bar arithmetic
    logic [TB:0]         w_diff;
    logic [TB-1:0]       w_mag;
    logic [TB-1:0]       w_divisor;
    logic [TB:0]         w_power_limit;
    logic [TW-1:0]       w_limit;
    logic [LEN_W-1:0]    w_q_signed;
    logic [LEN_W-1:0]    w_len;
    logic [BAR_LEDS-1:0] w_pattern;

    assign w_pressed      = s_axis_tdata[0];
    assign w_press_time   = s_axis_tdata[TB:1];
    assign w_release_time = s_axis_tdata[2*TB:TB+1];

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp      <= sbsu_pkg::RST_MIN_TEMP;
            r_max_adult     <= sbsu_pkg::RST_MAX_TEMP_ADULT;
            r_max_child     <= sbsu_pkg::RST_MAX_TEMP_CHILD;
            r_long_press    <= sbsu_pkg::RST_LONG_PRESS;
            r_on_off_limit  <= sbsu_pkg::RST_ON_OFF_LIMIT;
            r_activity_done <= sbsu_pkg::RST_ACTIVITY_DONE;
            r_bar_period    <= sbsu_pkg::RST_BAR_PERIOD;
            r_temp_range    <= sbsu_pkg::RST_TEMP_RANGE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbsu_pkg::REG_MIN_TEMP:       r_min_temp      <= i_cfg_data[TW-1:0];
                sbsu_pkg::REG_MAX_TEMP_ADULT: r_max_adult     <= i_cfg_data[TW-1:0];
                sbsu_pkg::REG_MAX_TEMP_CHILD: r_max_child     <= i_cfg_data[TW-1:0];
                sbsu_pkg::REG_LONG_PRESS:     r_long_press    <= i_cfg_data[TB-1:0];
                sbsu_pkg::REG_ON_OFF_LIMIT:   r_on_off_limit  <= i_cfg_data[TB-1:0];
                sbsu_pkg::REG_ACTIVITY_DONE:  r_activity_done <= i_cfg_data[TB-1:0];
                sbsu_pkg::REG_BAR_PERIOD:     r_bar_period    <= i_cfg_data[TB-1:0];
                sbsu_pkg::REG_TEMP_RANGE:     r_temp_range    <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    assign w_limit       = r_adult ? r_max_adult : r_max_child;
    assign w_power_limit = {1'b0, r_on_off_limit} + {1'b0, r_long_press};

    // Signed hold time past the long-press time, split into sign and magnitude
    assign w_diff    = {1'b0, w_press_time} - {1'b0, r_long_press};
    assign w_mag     = w_diff[TB] ? TB'(-w_diff) : w_diff[TB-1:0];
    assign w_divisor = (r_bar_period == '0) ? TB'(1) : r_bar_period;

    // Apply one poll to the button state
    always_comb begin
        n_was_pressed  = w_pressed;
        n_longest_hold = r_longest_hold;
        n_edit_temp    = r_edit_temp;
        n_arm_power    = r_arm_power;
        n_edit_mode    = r_edit_mode;
        n_skip_first   = r_skip_first;
        n_setpoint     = r_setpoint;
        n_target       = r_target;
        n_power        = r_power;
        n_adult        = r_adult;
        n_beep         = w_pressed && !r_was_pressed;
        n_bar_upd      = 1'b0;
        n_store        = 1'b0;
        w_need_bar     = 1'b0;

        if (!w_pressed && r_was_pressed) begin
            // Release: step setpoint, finish arming, toggle mode, start editing
            if (r_edit_temp) begin
                if (r_setpoint < w_limit) begin
                    n_setpoint = r_setpoint + 1'b1;
                end else begin
                    n_setpoint = r_min_temp;
                end
            end
            if (r_arm_power) begin
                if ({1'b0, r_longest_hold} >= w_power_limit) begin
                    n_power = !r_power;
                    n_store = 1'b1;
                end
                n_arm_power = 1'b0;
                n_bar_upd   = 1'b1;
            end
            if (r_edit_mode) begin
                if (r_skip_first) begin
                    n_skip_first = 1'b0;
                end else begin
                    n_adult = !r_adult;
                end
            end
            if (r_longest_hold < r_long_press && !r_busy && n_power) begin
                n_edit_temp = 1'b1;
            end
            n_longest_hold = '0;
        end else if (w_pressed && r_was_pressed) begin
            // Hold: long press switches editing or arms power
            if (w_press_time >= r_long_press) begin
                if (r_edit_temp) begin
                    n_edit_mode  = 1'b1;
                    n_edit_temp  = 1'b0;
                    n_skip_first = 1'b1;
                end
                if (!r_busy) begin
                    n_arm_power = 1'b1;
                end
            end
            if (n_arm_power) begin
                n_bar_upd  = 1'b1;
                w_need_bar = 1'b1;
            end
            n_longest_hold = w_press_time;
        end else if (!w_pressed && !r_was_pressed) begin
            // Idle: commit edits after the activity timeout
            if (w_release_time > r_activity_done) begin
                if (r_edit_temp) begin
                    n_target    = r_setpoint;
                    n_edit_temp = 1'b0;
                    n_store     = 1'b1;
                end
                if (r_edit_mode) begin
                    if (n_target > r_max_child && !r_adult) begin
                        n_target = r_max_child;
                    end
                    n_setpoint  = n_target;
                    n_edit_mode = 1'b0;
                    n_store     = 1'b1;
                end
            end
        end

        n_busy = n_edit_temp || n_arm_power || n_edit_mode;
    end

    // Button state and poll status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_pressed  <= 1'b0;
            r_longest_hold <= '0;
            r_edit_temp    <= 1'b0;
            r_arm_power    <= 1'b0;
            r_edit_mode    <= 1'b0;
            r_skip_first   <= 1'b0;
            r_busy         <= 1'b0;
            r_setpoint     <= TW'(DEFAULT_SETPOINT);
            r_target       <= TW'(DEFAULT_SETPOINT);
            r_power        <= 1'b1;
            r_adult        <= 1'b1;
        end else if (w_accept) begin
            r_was_pressed  <= n_was_pressed;
            r_longest_hold <= n_longest_hold;
            r_edit_temp    <= n_edit_temp;
            r_arm_power    <= n_arm_power;
            r_edit_mode    <= n_edit_mode;
            r_skip_first   <= n_skip_first;
            r_busy         <= n_busy;
            r_setpoint     <= n_setpoint;
            r_target       <= n_target;
            r_power        <= n_power;
            r_adult        <= n_adult;
        end
    end

    // Result payload; the bar is blank unless the divide fills it in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_beep       <= n_beep;
            r_bar_upd    <= n_bar_upd;
            r_store      <= n_store;
            r_pattern    <= '0;
            r_neg        <= w_diff[TB];
            r_count_down <= r_power;
        end else if (r_state == sbsu_pkg::ST_BAR) begin
            r_pattern    <= w_pattern;
        end
    end

    // Divider for the bar length
    sbsu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Bar length: signed quotient, counted down from the start length while power is on
    assign w_q_signed = r_neg ? LEN_W'(-{2'b00, w_quot}) : {2'b00, w_quot};
    assign w_len      = r_count_down ? (LEN_W'(r_temp_range) - w_q_signed) : w_q_signed;

    // Light LED i when i is below the length
    always_comb begin
        for (int i = 0; i < BAR_LEDS; i++) begin
            w_pattern[i] = $signed(w_len) > $signed(LEN_W'(i));
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbsu_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_bar ? sbsu_pkg::ST_DIV : sbsu_pkg::ST_OUT;
                end
            end
            sbsu_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = sbsu_pkg::ST_BAR;
                end
            end
            sbsu_pkg::ST_BAR: begin
                n_state = sbsu_pkg::ST_OUT;
            end
            sbsu_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = sbsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbsu_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            sbsu_pkg::ST_IDLE: s_axis_tready = 1'b1;
            sbsu_pkg::ST_OUT:  m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign w_div_start = w_accept && w_need_bar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbsu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pack the result transfer
    assign m_axis_tdata = OUT_PW'({r_edit_mode, r_arm_power, r_edit_temp, r_busy, r_store,
                                   r_adult, r_power, r_target, r_setpoint, r_pattern,
                                   r_bar_upd, r_beep});

endmodule

`default_nettype wire

>>> hw/rtl/sbsu_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sbsu_pkg for the timer width.
`default_nettype none

module sbsu_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [sbsu_pkg::TIMER_BITS-1:0] i_dividend,
    input  wire logic [sbsu_pkg::TIMER_BITS-1:0] i_divisor,
    output logic                                 o_done,
    output logic [sbsu_pkg::TIMER_BITS-1:0]      o_quot
);

    localparam int TB    = sbsu_pkg::TIMER_BITS;
    localparam int CNT_W = $clog2(TB);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TB-1:0]    r_rem, n_rem;
    logic [TB-1:0]    r_quo, n_quo;
    logic [TB-1:0]    r_dvs;

    logic [TB:0]      w_shift;
    logic [TB:0]      w_trial;

    // Shift in the next dividend bit and try the subtraction
    assign w_shift = {r_rem, r_quo[TB-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (!w_trial[TB]) begin
                n_rem = w_trial[TB-1:0];
                n_quo = {r_quo[TB-2:0], 1'b1};
            end else begin
                n_rem = w_shift[TB-1:0];
                n_quo = {r_quo[TB-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(TB - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath: hold the divisor for the whole run
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

>>> dv/tb_single_button_setpoint_ui.sv
// Self-checking testbench for the single-button setpoint user interface.
// Drives button polls over the stream port and checks every result against a local predictor.
// Depends on sbsu_pkg and the single_button_setpoint_ui RTL.
`timescale 1ns / 1ps

module tb_single_button_setpoint_ui;

    localparam int RES_W       = ((sbsu_pkg::BAR_LEDS_DEF + 23 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_POLLS = 175;
    localparam int SETTLE      = sbsu_pkg::TIMER_BITS + 8;

    // Result fields, highest bit first, so the struct overlays m_axis_tdata
    typedef struct packed {
        logic       pad;
        logic       editing_mode;
        logic       arming_power;
        logic       editing_setpoint;
        logic       busy_res;
        logic       store_request;
        logic       adult_on;
        logic       power_on;
        logic [6:0] target_temp;
        logic [6:0] setpoint;
        logic [7:0] bar_pattern;
        logic       bar_update;
        logic       beep_start;
    } t_ui_result;

    // Predictor of the button sequencer plus the queue of results still due
    class t_setpoint_ui_scoreboard;
        logic [6:0]  cfg_min_temp, cfg_max_adult, cfg_max_child;
        logic [15:0] cfg_hold_long, cfg_power_hold, cfg_quiet_time, cfg_step_ticks;
        logic [3:0]  cfg_bar_start;

        bit          btn_held_last, step_mode, power_arm, mode_edit;
        bit          mode_skip_pending, active_last, power_state, adult_state;
        logic [15:0] hold_peak;
        logic [6:0]  sp_value, tgt_value;

        t_ui_result  ui_updates_due[$];
        int          errors;
        int          checked;

        function new();
            cfg_min_temp   = sbsu_pkg::RST_MIN_TEMP;
            cfg_max_adult  = sbsu_pkg::RST_MAX_TEMP_ADULT;
            cfg_max_child  = sbsu_pkg::RST_MAX_TEMP_CHILD;
            cfg_hold_long  = sbsu_pkg::RST_LONG_PRESS;
            cfg_power_hold = sbsu_pkg::RST_ON_OFF_LIMIT;
            cfg_quiet_time = sbsu_pkg::RST_ACTIVITY_DONE;
            cfg_step_ticks = sbsu_pkg::RST_BAR_PERIOD;
            cfg_bar_start  = sbsu_pkg::RST_TEMP_RANGE;
            btn_held_last = 1'b0;
            hold_peak     = '0;
            step_mode     = 1'b0;
            power_arm     = 1'b0;
            mode_edit     = 1'b0;
            mode_skip_pending = 1'b0;
            active_last   = 1'b0;
            sp_value      = 7'(sbsu_pkg::DEFAULT_SETPOINT_DEF);
            tgt_value     = 7'(sbsu_pkg::DEFAULT_SETPOINT_DEF);
            power_state   = 1'b1;
            adult_state   = 1'b1;
            errors        = 0;
            checked       = 0;
        endfunction

        function void set_reg(logic [sbsu_pkg::CFG_IDX_W-1:0] idx,
                              logic [sbsu_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sbsu_pkg::REG_MIN_TEMP:       cfg_min_temp   = val[6:0];
                sbsu_pkg::REG_MAX_TEMP_ADULT: cfg_max_adult  = val[6:0];
                sbsu_pkg::REG_MAX_TEMP_CHILD: cfg_max_child  = val[6:0];
                sbsu_pkg::REG_LONG_PRESS:     cfg_hold_long  = val;
                sbsu_pkg::REG_ON_OFF_LIMIT:   cfg_power_hold = val;
                sbsu_pkg::REG_ACTIVITY_DONE:  cfg_quiet_time = val;
                sbsu_pkg::REG_BAR_PERIOD:     cfg_step_ticks = val;
                sbsu_pkg::REG_TEMP_RANGE:     cfg_bar_start  = val[3:0];
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted poll and queue it
        function void predict_poll(bit btn_down, logic [15:0] press_ticks,
                                   logic [15:0] rel_ticks);
            t_ui_result r;
            logic [6:0] limit;
            int         diff, per, steps, bar_len;
            r = '0;

            if (btn_down && !btn_held_last)
                r.beep_start = 1'b1;

            // Button let go
            if (!btn_down && btn_held_last) begin
                if (step_mode) begin
                    limit = adult_state ? cfg_max_adult : cfg_max_child;
                    if (sp_value < limit)
                        sp_value = sp_value + 7'd1;
                    else
                        sp_value = cfg_min_temp;
                end
                if (power_arm) begin
                    if (int'(hold_peak) >= int'(cfg_power_hold) + int'(cfg_hold_long)) begin
                        power_state     = !power_state;
                        r.store_request = 1'b1;
                    end
                    power_arm     = 1'b0;
                    r.bar_update  = 1'b1;
                    r.bar_pattern = '0;
                end
                if (mode_edit) begin
                    if (mode_skip_pending)
                        mode_skip_pending = 1'b0;
                    else
                        adult_state = !adult_state;
                end
                if (hold_peak < cfg_hold_long && !active_last && power_state)
                    step_mode = 1'b1;
                hold_peak = '0;
            end

            // Button still held
            if (btn_down && btn_held_last) begin
                if (press_ticks >= cfg_hold_long) begin
                    if (step_mode) begin
                        mode_edit         = 1'b1;
                        step_mode         = 1'b0;
                        mode_skip_pending = 1'b1;
                    end
                    if (!active_last)
                        power_arm = 1'b1;
                end
                if (power_arm) begin
                    // signed hold difference, truncated toward zero
                    diff    = int'(press_ticks) - int'(cfg_hold_long);
                    per     = (cfg_step_ticks == '0) ? 1 : int'(cfg_step_ticks);
                    steps   = diff / per;
                    bar_len = power_state ? int'(cfg_bar_start) - steps : steps;
                    r.bar_update = 1'b1;
                    if (bar_len <= 0)
                        r.bar_pattern = '0;
                    else if (bar_len >= 8)
                        r.bar_pattern = 8'hFF;
                    else
                        r.bar_pattern = 8'((1 << bar_len) - 1);
                end
                hold_peak = press_ticks;
            end

            // Button idle: commit pending edits after the quiet time
            if (!btn_down && !btn_held_last && rel_ticks > cfg_quiet_time) begin
                if (step_mode) begin
                    tgt_value       = sp_value;
                    step_mode       = 1'b0;
                    r.store_request = 1'b1;
                end
                if (mode_edit) begin
                    if (tgt_value > cfg_max_child && !adult_state)
                        tgt_value = cfg_max_child;
                    sp_value        = tgt_value;
                    mode_edit       = 1'b0;
                    r.store_request = 1'b1;
                end
            end

            active_last   = step_mode || power_arm || mode_edit;
            btn_held_last = btn_down;

            r.setpoint         = sp_value;
            r.target_temp      = tgt_value;
            r.power_on         = power_state;
            r.adult_on         = adult_state;
            r.busy_res         = active_last;
            r.editing_setpoint = step_mode;
            r.arming_power     = power_arm;
            r.editing_mode     = mode_edit;
            ui_updates_due.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $realtime, checked, what, got, want);
            errors++;
        endtask

        task compare_field(string what, int got, int want);
            if (got != want)
                report_mismatch(what, got, want);
        endtask

        // Compare one transferred result with the oldest one due
        task check_result(logic [RES_W-1:0] word);
            t_ui_result got, want;
            got = t_ui_result'(word);
            if (ui_updates_due.size() == 0) begin
                report_mismatch("unexpected result", int'(word), 0);
            end else begin
                want = ui_updates_due.pop_front();
                compare_field("beep_start",       got.beep_start,       want.beep_start);
                compare_field("bar_update",       got.bar_update,       want.bar_update);
                compare_field("bar_pattern",      got.bar_pattern,      want.bar_pattern);
                compare_field("setpoint",         got.setpoint,         want.setpoint);
                compare_field("target_temp",      got.target_temp,      want.target_temp);
                compare_field("power_on",         got.power_on,         want.power_on);
                compare_field("adult_on",         got.adult_on,         want.adult_on);
                compare_field("store_request",    got.store_request,    want.store_request);
                compare_field("busy_res",         got.busy_res,         want.busy_res);
                compare_field("editing_setpoint", got.editing_setpoint, want.editing_setpoint);
                compare_field("arming_power",     got.arming_power,     want.arming_power);
                compare_field("editing_mode",     got.editing_mode,     want.editing_mode);
            end
            checked++;
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sbsu_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sbsu_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [39:0]                     s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [RES_W-1:0]                m_axis_tdata;

    t_setpoint_ui_scoreboard ui_model;
    int                      src_idle_pct;
    int                      sink_stall_pct;
    int                      cycle_count = 0;

    single_button_setpoint_ui dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("single_button_setpoint_ui regression: fail");
            $finish;
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    // Observe both streams at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                ui_model.predict_poll(s_axis_tdata[0], s_axis_tdata[16:1], s_axis_tdata[32:17]);
            if (m_axis_tvalid && m_axis_tready)
                ui_model.check_result(m_axis_tdata);
        end
    end

    function automatic logic [15:0] clamp_ticks(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    // Offer one poll and hold it until the transfer
    task automatic send_poll(input bit btn_down, input int press_ticks, input int rel_ticks);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, clamp_ticks(rel_ticks), clamp_ticks(press_ticks), btn_down};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for every result, then let the sequencer settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (ui_model.ui_updates_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random button gestures scaled to the current timing registers
    task automatic run_gestures(input int budget);
        int sent, pick, n, k, top, lp, lim, quiet, pt;
        sent = 0;
        while (sent < budget) begin
            lp    = int'(ui_model.cfg_hold_long);
            lim   = lp + int'(ui_model.cfg_power_hold);
            quiet = int'(ui_model.cfg_quiet_time);
            pick  = $urandom_range(99);
            if (pick < 35) begin
                // short tap
                n = $urandom_range(1, 3);
                send_poll(1'b1, $urandom_range(65535), $urandom_range(65535));
                for (k = 1; k < n; k++)
                    send_poll(1'b1, (lp > 0) ? $urandom_range(lp - 1) : 0, 0);
                send_poll(1'b0, $urandom_range(65535), $urandom_range(65535));
                sent += n + 1;
            end else if (pick < 65) begin
                // long hold, mostly reaching the power limit
                n = $urandom_range(2, 10);
                case ($urandom_range(3))
                    0:       top = $urandom_range(lim, lp);
                    1, 2:    top = lim + $urandom_range(2000);
                    default: top = $urandom_range(65535);
                endcase
                send_poll(1'b1, 0, $urandom_range(65535));
                for (k = 1; k <= n; k++) begin
                    pt = (top * k) / n;
                    if ($urandom_range(7) == 0)
                        pt = $urandom_range(lp);
                    send_poll(1'b1, pt, 0);
                end
                send_poll(1'b0, 0, 0);
                sent += n + 2;
            end else if (pick < 85) begin
                // quiet polls, often past the commit time
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    send_poll(1'b0, $urandom_range(65535),
                              $urandom_range(1) ? quiet + $urandom_range(1, 2000)
                                                : $urandom_range(quiet));
                sent += n;
            end else begin
                send_poll($urandom_range(1), $urandom_range(65535), $urandom_range(65535));
                sent++;
            end
        end
    endtask

    initial begin
        int cfg_val [8];
        int ph, ri;

        ui_model       = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= sbsu_pkg::REG_MIN_TEMP;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through the user interface at reset settings
        send_poll(1'b0, 0, 0);
        send_poll(1'b1, 0, 65535);              // press edge beeps
        send_poll(1'b0, 65535, 0);              // short release starts editing
        send_poll(1'b1, 0, 0);
        send_poll(1'b0, 0, 0);                  // step up to the adult limit
        send_poll(1'b1, 0, 0);
        send_poll(1'b0, 0, 0);                  // at the limit: wrap to minimum
        send_poll(1'b1, 0, 0);
        send_poll(1'b1, 1500, 0);               // long hold switches to mode editing
        send_poll(1'b0, 0, 0);                  // first release skipped
        send_poll(1'b1, 0, 0);
        send_poll(1'b0, 0, 0);                  // toggle to child mode
        send_poll(1'b0, 0, 3001);               // commit with child clamp
        send_poll(1'b1, 0, 0);
        send_poll(1'b1, 1000, 0);               // arm power, full bar
        send_poll(1'b1, 2500, 0);               // countdown
        send_poll(1'b1, 500, 0);                // hold below long press while armed
        send_poll(1'b1, 4100, 0);               // bar empty
        send_poll(1'b1, 65535, 0);              // negative length
        send_poll(1'b0, 0, 0);                  // power off, store, blank bar
        send_poll(1'b1, 0, 0);
        send_poll(1'b1, 4000, 0);               // count up while off
        send_poll(1'b1, 1750, 0);
        send_poll(1'b0, 0, 0);                  // short of the limit: no toggle
        send_poll(1'b1, 0, 0);
        send_poll(1'b0, 0, 0);                  // no editing while off

        for (ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: begin
                        cfg_val[sbsu_pkg::REG_MIN_TEMP]       = 0;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_ADULT] = 127;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_CHILD] = 127;
                        cfg_val[sbsu_pkg::REG_LONG_PRESS]     = 0;
                        cfg_val[sbsu_pkg::REG_ON_OFF_LIMIT]   = 0;
                        cfg_val[sbsu_pkg::REG_ACTIVITY_DONE]  = 0;
                        cfg_val[sbsu_pkg::REG_BAR_PERIOD]     = 1;
                        cfg_val[sbsu_pkg::REG_TEMP_RANGE]     = 0;
                    end
                    2: begin
                        // power limit beyond the timer range
                        cfg_val[sbsu_pkg::REG_MIN_TEMP]       = 127;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_ADULT] = 0;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_CHILD] = 0;
                        cfg_val[sbsu_pkg::REG_LONG_PRESS]     = 65535;
                        cfg_val[sbsu_pkg::REG_ON_OFF_LIMIT]   = 65535;
                        cfg_val[sbsu_pkg::REG_ACTIVITY_DONE]  = 65535;
                        cfg_val[sbsu_pkg::REG_BAR_PERIOD]     = 65535;
                        cfg_val[sbsu_pkg::REG_TEMP_RANGE]     = 8;
                    end
                    3: begin
                        // zero bar period counts as one
                        cfg_val[sbsu_pkg::REG_MIN_TEMP]       = 20;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_ADULT] = 25;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_CHILD] = 22;
                        cfg_val[sbsu_pkg::REG_LONG_PRESS]     = 100;
                        cfg_val[sbsu_pkg::REG_ON_OFF_LIMIT]   = 300;
                        cfg_val[sbsu_pkg::REG_ACTIVITY_DONE]  = 200;
                        cfg_val[sbsu_pkg::REG_BAR_PERIOD]     = 0;
                        cfg_val[sbsu_pkg::REG_TEMP_RANGE]     = 5;
                    end
                    4: begin
                        cfg_val[sbsu_pkg::REG_MIN_TEMP]       = $urandom_range(60);
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_ADULT] =
                            cfg_val[sbsu_pkg::REG_MIN_TEMP] + $urandom_range(20);
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_CHILD] =
                            $urandom_range(cfg_val[sbsu_pkg::REG_MAX_TEMP_ADULT],
                                           cfg_val[sbsu_pkg::REG_MIN_TEMP]);
                        cfg_val[sbsu_pkg::REG_LONG_PRESS]     = $urandom_range(50, 2000);
                        cfg_val[sbsu_pkg::REG_ON_OFF_LIMIT]   = $urandom_range(3000);
                        cfg_val[sbsu_pkg::REG_ACTIVITY_DONE]  = $urandom_range(100, 5000);
                        cfg_val[sbsu_pkg::REG_BAR_PERIOD]     = $urandom_range(1, 500);
                        cfg_val[sbsu_pkg::REG_TEMP_RANGE]     = $urandom_range(8);
                    end
                    default: begin
                        // child limit above the adult limit
                        cfg_val[sbsu_pkg::REG_MIN_TEMP]       = 10;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_ADULT] = 12;
                        cfg_val[sbsu_pkg::REG_MAX_TEMP_CHILD] = 40;
                        cfg_val[sbsu_pkg::REG_LONG_PRESS]     = 500;
                        cfg_val[sbsu_pkg::REG_ON_OFF_LIMIT]   = 1000;
                        cfg_val[sbsu_pkg::REG_ACTIVITY_DONE]  = 1000;
                        cfg_val[sbsu_pkg::REG_BAR_PERIOD]     = 60;
                        cfg_val[sbsu_pkg::REG_TEMP_RANGE]     = 3;
                    end
                endcase
                // Hold the write enable across all eight registers
                for (ri = 0; ri < 8; ri++) begin
                    i_cfg_we   <= 1'b1;
                    i_cfg_idx  <= sbsu_pkg::CFG_IDX_W'(ri);
                    i_cfg_data <= sbsu_pkg::CFG_DATA_W'(cfg_val[ri]);
                    @(posedge i_clk);
                    ui_model.set_reg(sbsu_pkg::CFG_IDX_W'(ri),
                                     sbsu_pkg::CFG_DATA_W'(cfg_val[ri]));
                end
                i_cfg_we <= 1'b0;
            end

            // Rotate through the idle patterns
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            run_gestures(PHASE_POLLS);
        end

        drain_results();
        if (ui_model.ui_updates_due.size() != 0)
            ui_model.report_mismatch("results never seen", ui_model.ui_updates_due.size(), 0);
        if (ui_model.errors == 0)
            $display("single_button_setpoint_ui regression: pass");
        else
            $display("single_button_setpoint_ui regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sbsu_pkg.sv
hw/rtl/sbsu_div.sv
hw/rtl/single_button_setpoint_ui.sv
dv/tb_single_button_setpoint_ui.sv
